// File: design/kda_pkg.sv
// ----------------------------------------------------------------------------
// Key qualifier package
// Types and constants shared by the key debounce / auto-repeat block.
// ----------------------------------------------------------------------------
package kda_pkg;

	// Key phase codes
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_DEBOUNCE = 3'd1;
	localparam logic [2:0] PH_HOLD     = 3'd2;
	localparam logic [2:0] PH_WAIT     = 3'd3;
	localparam logic [2:0] PH_REPEAT   = 3'd4;

	// Item operation codes
	localparam logic OP_POLL = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes
	localparam logic CFG_REPEAT_PERIOD = 1'b0;
	localparam logic CFG_REPEAT_DELAY  = 1'b1;

	// Timing constants, in ticks, and the menu wrap limit
	localparam logic [15:0] DEBOUNCE_TICKS = 16'd5;
	localparam logic [15:0] HOLD_TICKS     = 16'd3;
	localparam logic [15:0] DEF_PERIOD     = 16'd20;
	localparam logic [15:0] DEF_DELAY      = 16'd150;
	localparam logic [12:0] MENU_TICKS     = 13'd4000;
	localparam logic [12:0] MENU_IN_TICKS  = 13'd5000;
	localparam logic [7:0]  MENU_WRAP      = 8'd14;

	// Qualifier state
	typedef struct packed {
		logic [2:0]  phase;
		logic [3:0]  owner;
		logic [15:0] key_cnt;
		logic [12:0] menu_cnt;
		logic [7:0]  menu_sel;
		logic        backlight;
	} kda_state_t;

	// Result beat payload
	typedef struct packed {
		logic       push_pulse;
		logic       repeat_pulse;
		logic       lamp_on;
		logic [7:0] menu_slot;
	} kda_result_t;

endpackage

// File: design/kda_if.sv
// ----------------------------------------------------------------------------
// Key qualifier channels
// Valid/ready channels for poll/tick items and for result beats.
// ----------------------------------------------------------------------------
interface kda_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [3:0] key_id;
	logic       key_pressed;

	modport source (output valid, output op, output key_id, output key_pressed, input ready);
	modport sink   (input valid, input op, input key_id, input key_pressed, output ready);
endinterface

interface kda_out_if;
	logic       valid;
	logic       ready;
	logic       push_pulse;
	logic       repeat_pulse;
	logic       lamp_on;
	logic [7:0] menu_slot;

	modport source (output valid, output push_pulse, output repeat_pulse,
		output lamp_on, output menu_slot, input ready);
	modport sink   (input valid, input push_pulse, input repeat_pulse,
		input lamp_on, input menu_slot, output ready);
endinterface

// File: design/key_debounce_autorepeat.sv
// A result beat passes through the input register, then the result register;
// an item is held in the input register until the result register can take it.
// Throughput: one item per cycle unless a result stalls; the state update sets it.
// An unaccepted result stalls the input register, then the input channel.
// Reset clears the qualifier state, both settings and all valid flags.
// ----------------------------------------------------------------------------
// Key debounce and auto-repeat qualifier
// Shared key qualifier with debounce, auto-repeat and menu inactivity timer.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat #(
	parameter int NUM_KEYS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	kda_in_if.sink       item,
	kda_out_if.source    result,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);

	logic [15:0]          repeat_period_q;
	logic [15:0]          repeat_delay_q;
	kda_pkg::kda_state_t  state_q;
	kda_pkg::kda_state_t  state_nxt;

	logic                 valid_s1;
	logic                 op_s1;
	logic [3:0]           key_id_s1;
	logic                 key_pressed_s1;

	logic                 out_valid_q;
	kda_pkg::kda_result_t out_q;

	logic                 advance;
	logic                 push;
	logic                 rep;

	// Stage 1 moves on when the result register is free or drained
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	// Settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_period_q <= '0;
			repeat_delay_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kda_pkg::CFG_REPEAT_PERIOD: repeat_period_q <= cfg_data;
				kda_pkg::CFG_REPEAT_DELAY:  repeat_delay_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1          <= item.op;
			key_id_s1      <= item.key_id;
			key_pressed_s1 <= item.key_pressed;
		end
	end

	kda_step #(
		.NUM_KEYS (NUM_KEYS)
	) u_step (
		.cur           (state_q),
		.op            (op_s1),
		.key_id        (key_id_s1),
		.key_pressed   (key_pressed_s1),
		.repeat_period (repeat_period_q),
		.repeat_delay  (repeat_delay_q),
		.nxt           (state_nxt),
		.push_pulse    (push),
		.repeat_pulse  (rep)
	);

	// Qualifier state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.push_pulse   <= push;
			out_q.repeat_pulse <= rep;
			out_q.lamp_on      <= state_nxt.backlight;
			out_q.menu_slot    <= state_nxt.menu_sel;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.push_pulse   = out_q.push_pulse;
	assign result.repeat_pulse = out_q.repeat_pulse;
	assign result.lamp_on      = out_q.lamp_on;
	assign result.menu_slot    = out_q.menu_slot;

endmodule

// File: design/kda_step.sv
// ----------------------------------------------------------------------------
// Key qualifier next-state logic
// Applies one poll or tick to the qualifier state and forms the pulses.
// ----------------------------------------------------------------------------
module kda_step #(
	parameter int NUM_KEYS = 8
) (
	input  kda_pkg::kda_state_t cur,
	input  logic                op,
	input  logic [3:0]          key_id,
	input  logic                key_pressed,
	input  logic [15:0]         repeat_period,
	input  logic [15:0]         repeat_delay,
	output kda_pkg::kda_state_t nxt,
	output logic                push_pulse,
	output logic                repeat_pulse
);

	localparam logic [3:0] KEY_MAX = 4'(NUM_KEYS);

	logic        ignore;
	logic [15:0] delay_eff;
	logic [15:0] period_eff;

	// Zero settings select the defaults
	assign delay_eff  = (repeat_delay  != '0) ? repeat_delay  : kda_pkg::DEF_DELAY;
	assign period_eff = (repeat_period != '0) ? repeat_period : kda_pkg::DEF_PERIOD;

	// Drop polls of a foreign key or a key out of range
	assign ignore = ((cur.owner != '0) && (cur.owner != key_id))
		|| (key_id == '0) || (key_id > KEY_MAX);

	always_comb begin
		nxt          = cur;
		push_pulse   = 1'b0;
		repeat_pulse = 1'b0;

		if (op == kda_pkg::OP_TICK) begin
			// Count both timers down toward zero
			if (cur.key_cnt != '0)
				nxt.key_cnt = cur.key_cnt - 16'd1;
			if (cur.menu_cnt != '0)
				nxt.menu_cnt = cur.menu_cnt - 13'd1;
		end else if (!ignore) begin
			// Start debounce, or refresh backlight and menu
			if (key_pressed && (cur.phase == kda_pkg::PH_IDLE)) begin
				nxt.phase   = kda_pkg::PH_DEBOUNCE;
				nxt.key_cnt = kda_pkg::DEBOUNCE_TICKS;
			end else if (cur.menu_cnt == '0) begin
				nxt.menu_sel  = '0;
				nxt.backlight = 1'b0;
			end else begin
				nxt.backlight = 1'b1;
			end

			// Advance the key phase
			if (nxt.phase != kda_pkg::PH_IDLE) begin
				if (key_pressed && (nxt.phase == kda_pkg::PH_DEBOUNCE)
					&& (nxt.key_cnt == '0)) begin
					nxt.menu_cnt = kda_pkg::MENU_TICKS;
					nxt.phase    = kda_pkg::PH_HOLD;
					nxt.key_cnt  = kda_pkg::HOLD_TICKS;
					nxt.owner    = key_id;
					if (nxt.menu_sel != '0) begin
						nxt.menu_cnt = kda_pkg::MENU_IN_TICKS;
						nxt.menu_sel = nxt.menu_sel + 8'd1;
					end
					if (nxt.menu_sel >= kda_pkg::MENU_WRAP)
						nxt.menu_sel = 8'd1;
				end else if (!key_pressed && ((nxt.phase == kda_pkg::PH_HOLD)
					|| (nxt.phase == kda_pkg::PH_WAIT))) begin
					push_pulse = 1'b1;
					nxt.phase  = kda_pkg::PH_IDLE;
					nxt.owner  = '0;
				end else if (key_pressed && (nxt.phase == kda_pkg::PH_HOLD)
					&& (nxt.key_cnt == '0)) begin
					nxt.phase   = kda_pkg::PH_WAIT;
					nxt.key_cnt = delay_eff;
				end else if (key_pressed && (nxt.phase == kda_pkg::PH_WAIT)
					&& (nxt.key_cnt == '0)) begin
					nxt.phase = kda_pkg::PH_REPEAT;
				end else if (key_pressed && (nxt.phase == kda_pkg::PH_REPEAT)
					&& (nxt.key_cnt == '0)) begin
					nxt.key_cnt  = period_eff;
					nxt.menu_sel = nxt.menu_sel + 8'd1;
					nxt.menu_cnt = kda_pkg::MENU_TICKS;
					repeat_pulse = 1'b1;
				end
			end

			// Release in wait or repeat returns to idle
			if ((nxt.phase >= kda_pkg::PH_WAIT) && !key_pressed) begin
				nxt.phase = kda_pkg::PH_IDLE;
				nxt.owner = '0;
			end
		end
	end

endmodule

// File: design/kda_checker.sv
// ----------------------------------------------------------------------------
// Key qualifier port checker
// Watches the ports of the qualifier top level over time.
// ----------------------------------------------------------------------------
module kda_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       push_pulse,
	input logic       repeat_pulse,
	input logic       lamp_on,
	input logic [7:0] menu_slot
);

	// A beat never carries both a push and a repeat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(push_pulse && repeat_pulse))
		else $error("push and repeat pulse in one beat");

	// Input back-pressure only comes from a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a stalled result");

	// Hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result beat dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(push_pulse) && $stable(repeat_pulse)
			&& $stable(lamp_on) && $stable(menu_slot)))
		else $error("stalled result payload changed");

endmodule

bind key_debounce_autorepeat kda_checker u_kda_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (item.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.push_pulse   (result.push_pulse),
	.repeat_pulse (result.repeat_pulse),
	.lamp_on      (result.lamp_on),
	.menu_slot    (result.menu_slot)
);

// File: verif/key_debounce_autorepeat_test.sv
// ----------------------------------------------------------------------------
// Key debounce and auto-repeat qualifier testbench
// Drives poll and tick items into the qualifier with random source gaps and
// result stalls. An in-bench model of the five-phase key machine and the menu
// timer predicts every result beat, and a checker compares each beat field by
// field. Directed tests cover out-of-range keys, the release paths, both
// setting extremes, the default settings and menu wrap. They are followed by
// random press sessions under several settings.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat_test;

	localparam int KEYS           = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 4;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	kda_in_if  item_ch ();
	kda_out_if result_ch ();

	key_debounce_autorepeat #(
		.NUM_KEYS(KEYS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Model copy of the qualifier state and settings
	logic [2:0]  q_phase;
	logic [3:0]  q_owner;
	logic [15:0] q_key_cnt;
	logic [12:0] q_menu_cnt;
	logic [7:0]  q_menu_sel;
	logic        q_backlight;
	logic [15:0] q_period;
	logic [15:0] q_delay;

	kda_pkg::kda_result_t expected_beats[$];
	int          mismatches  = 0;
	int          items_sent  = 0;
	bit          src_calm    = 1'b0;
	bit          sink_calm   = 1'b0;
	int          stall_left  = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Gap length: mostly none, sometimes short, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Advance the key machine by one item and return the beat it produces
	function automatic kda_pkg::kda_result_t qualify_item(input logic op,
			input logic [3:0] k, input logic pressed);
		kda_pkg::kda_result_t beat;
		beat.push_pulse = 1'b0;
		beat.repeat_pulse = 1'b0;
		if (op == kda_pkg::OP_TICK) begin
			if (q_key_cnt != 16'd0)
				q_key_cnt = q_key_cnt - 16'd1;
			if (q_menu_cnt != 13'd0)
				q_menu_cnt = q_menu_cnt - 13'd1;
		end else if (!((q_owner != 4'd0 && q_owner != k) || k == 4'd0 || k > KEYS)) begin
			if (pressed && q_phase == kda_pkg::PH_IDLE) begin
				q_phase = kda_pkg::PH_DEBOUNCE;
				q_key_cnt = kda_pkg::DEBOUNCE_TICKS;
			end else if (q_menu_cnt == 13'd0) begin
				q_menu_sel = 8'd0;
				q_backlight = 1'b0;
			end else begin
				q_backlight = 1'b1;
			end
			if (q_phase != kda_pkg::PH_IDLE) begin
				if (pressed && q_phase == kda_pkg::PH_DEBOUNCE && q_key_cnt == 16'd0) begin
					q_menu_cnt = kda_pkg::MENU_TICKS;
					q_phase = kda_pkg::PH_HOLD;
					q_key_cnt = kda_pkg::HOLD_TICKS;
					q_owner = k;
					if (q_menu_sel != 8'd0) begin
						q_menu_cnt = kda_pkg::MENU_IN_TICKS;
						q_menu_sel = q_menu_sel + 8'd1;
					end
					if (q_menu_sel >= kda_pkg::MENU_WRAP)
						q_menu_sel = 8'd1;
				end else if (!pressed && (q_phase == kda_pkg::PH_HOLD
						|| q_phase == kda_pkg::PH_WAIT)) begin
					beat.push_pulse = 1'b1;
					q_phase = kda_pkg::PH_IDLE;
					q_owner = 4'd0;
				end else if (pressed && q_phase == kda_pkg::PH_HOLD && q_key_cnt == 16'd0) begin
					q_phase = kda_pkg::PH_WAIT;
					q_key_cnt = (q_delay != 16'd0) ? q_delay : kda_pkg::DEF_DELAY;
				end else if (pressed && q_phase == kda_pkg::PH_WAIT && q_key_cnt == 16'd0) begin
					q_phase = kda_pkg::PH_REPEAT;
				end else if (pressed && q_phase == kda_pkg::PH_REPEAT
						&& q_key_cnt == 16'd0) begin
					q_key_cnt = (q_period != 16'd0) ? q_period : kda_pkg::DEF_PERIOD;
					q_menu_sel = q_menu_sel + 8'd1;
					q_menu_cnt = kda_pkg::MENU_TICKS;
					beat.repeat_pulse = 1'b1;
				end
			end
			if (q_phase >= kda_pkg::PH_WAIT && !pressed) begin
				q_phase = kda_pkg::PH_IDLE;
				q_owner = 4'd0;
			end
		end
		beat.lamp_on = q_backlight;
		beat.menu_slot = q_menu_sel;
		return beat;
	endfunction

	// Send one item and queue its predicted beat once accepted
	task automatic send_item(input logic op, input logic [3:0] key, input logic pressed);
		int gap;
		bit took;
		gap = src_calm ? 0 : pick_gap();
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.key_id <= key;
		item_ch.key_pressed <= pressed;
		do begin
			@(negedge clk);
			took = item_ch.ready;
			@(posedge clk);
		end while (!took);
		expected_beats.push_back(qualify_item(op, key, pressed));
		items_sent++;
	endtask

	task automatic poll(input logic [3:0] key, input logic pressed);
		send_item(kda_pkg::OP_POLL, key, pressed);
	endtask

	// Key fields of a tick are ignored, so randomize them
	task automatic tick();
		send_item(kda_pkg::OP_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
	endtask

	// Drop valid and wait until every expected beat has arrived
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one setting while the block is idle
	task automatic write_setting(input logic idx, input logic [15:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == kda_pkg::CFG_REPEAT_PERIOD)
			q_period = value;
		else
			q_delay = value;
		@(posedge clk);
	endtask

	task automatic write_settings(input logic [15:0] period, input logic [15:0] delay);
		write_setting(kda_pkg::CFG_REPEAT_PERIOD, period);
		write_setting(kda_pkg::CFG_REPEAT_DELAY, delay);
	endtask

	// Press a key through debounce into hold
	task automatic reach_hold(input logic [3:0] key);
		poll(key, 1'b1);
		while (q_key_cnt != 16'd0)
			tick();
		poll(key, 1'b1);
	endtask

	// Press a key through hold and wait-for-repeat into repeating
	task automatic reach_repeat(input logic [3:0] key);
		reach_hold(key);
		while (q_key_cnt != 16'd0)
			tick();
		poll(key, 1'b1);
		while (q_key_cnt != 16'd0)
			tick();
		poll(key, 1'b1);
	endtask

	// Out-of-range keys, ignored tick fields, debounce release, short push
	task automatic test_basics();
		poll(4'd0, 1'b1);
		poll(4'd15, 1'b1);
		poll(4'd9, 1'b0);
		send_item(kda_pkg::OP_TICK, 4'd15, 1'b1);
		send_item(kda_pkg::OP_TICK, 4'd0, 1'b0);
		poll(4'd8, 1'b1);
		poll(4'd8, 1'b0);
		repeat (kda_pkg::DEBOUNCE_TICKS) tick();
		poll(4'd8, 1'b1);
		poll(4'd1, 1'b1);
		poll(4'd8, 1'b0);
		poll(4'd1, 1'b0);
	endtask

	// Push from wait-for-repeat; silent release from repeating
	task automatic test_release_paths();
		write_settings(16'd1, 16'd2);
		reach_hold(4'd2);
		while (q_key_cnt != 16'd0)
			tick();
		poll(4'd2, 1'b1);
		poll(4'd2, 1'b0);
		reach_repeat(4'd5);
		poll(4'd5, 1'b1);
		poll(4'd5, 1'b0);
	endtask

	// Largest delay and largest period
	task automatic test_setting_extremes();
		write_settings(16'hFFFF, 16'hFFFF);
		reach_hold(4'd7);
		while (q_key_cnt != 16'd0)
			tick();
		poll(4'd7, 1'b1);
		repeat (4) tick();
		poll(4'd7, 1'b1);
		poll(4'd7, 1'b0);
		write_settings(16'hFFFF, 16'd1);
		reach_repeat(4'd4);
		poll(4'd4, 1'b1);
		repeat (3) tick();
		poll(4'd4, 1'b1);
		poll(4'd4, 1'b0);
	endtask

	// Zero settings select the default delay and period
	task automatic test_default_settings();
		write_settings(16'd0, 16'd0);
		src_calm = 1'b1;
		reach_repeat(4'd3);
		poll(4'd3, 1'b1);
		while (q_key_cnt != 16'd0)
			tick();
		poll(4'd3, 1'b1);
		poll(4'd3, 1'b0);
		src_calm = 1'b0;
	endtask

	// Repeat past 255 so the position wraps, then re-enter hold
	task automatic test_menu_wrap();
		write_settings(16'd1, 16'd1);
		src_calm = 1'b1;
		reach_repeat(4'd6);
		repeat (260) begin
			poll(4'd6, 1'b1);
			tick();
		end
		poll(4'd6, 1'b0);
		reach_hold(4'd6);
		poll(4'd6, 1'b0);
		src_calm = 1'b0;
	endtask

	// One random press session on a key, with noise and early releases
	task automatic press_session();
		logic [3:0] key;
		int         steps;
		int         r;
		if ($urandom_range(0, 9) == 0)
			key = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(KEYS + 1, 15));
		else
			key = 4'($urandom_range(1, KEYS));
		src_calm = ($urandom_range(0, 3) == 0);
		sink_calm = ($urandom_range(0, 3) == 0);
		poll(key, 1'b1);
		steps = $urandom_range(4, 60);
		repeat (steps) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				tick();
			else if (r < 85)
				poll(key, 1'b1);
			else if (r < 92)
				poll(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			else if (r < 96)
				poll(key, 1'b0);
			else if (r < 98)
				repeat ($urandom_range(10, 160)) tick();
			else
				tick();
		end
		poll(key, 1'b0);
		src_calm = 1'b0;
		sink_calm = 1'b0;
	endtask

	// Random sessions under several settings
	task automatic test_random_sessions();
		int          start;
		logic [15:0] period;
		logic [15:0] delay;
		for (int ph = 0; ph < 6; ph++) begin
			unique case (ph)
				0: begin period = 16'd1; delay = 16'd1; end
				1: begin period = 16'd2; delay = 16'd3; end
				2: begin
					period = 16'($urandom_range(1, 5));
					delay = 16'($urandom_range(1, 5));
				end
				3: begin period = 16'd0; delay = 16'd1; end
				4: begin period = 16'd1; delay = 16'd0; end
				default: begin
					period = 16'($urandom_range(0, 65535));
					delay = 16'($urandom_range(0, 65535));
				end
			endcase
			write_settings(period, delay);
			start = items_sent;
			while (items_sent - start < 40)
				press_session();
		end
	endtask

	// Drive result ready with random stalls
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted beat with the oldest prediction
	initial begin
		kda_pkg::kda_result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (expected_beats.size() == 0) begin
					$error("result beat with no prediction pending");
					mismatches++;
				end else begin
					want = expected_beats.pop_front();
					if (result_ch.push_pulse !== want.push_pulse) begin
						$error("push_pulse: expected %0d, got %0d",
							want.push_pulse, result_ch.push_pulse);
						mismatches++;
					end
					if (result_ch.repeat_pulse !== want.repeat_pulse) begin
						$error("repeat_pulse: expected %0d, got %0d",
							want.repeat_pulse, result_ch.repeat_pulse);
						mismatches++;
					end
					if (result_ch.lamp_on !== want.lamp_on) begin
						$error("lamp_on: expected %0d, got %0d",
							want.lamp_on, result_ch.lamp_on);
						mismatches++;
					end
					if (result_ch.menu_slot !== want.menu_slot) begin
						$error("menu_slot: expected %0d, got %0d",
							want.menu_slot, result_ch.menu_slot);
						mismatches++;
					end
				end
			end
		end
	end

	// End the run when no beat moves for too long
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	// Reset, run the tests in turn, report
	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = kda_pkg::OP_POLL;
		item_ch.key_id = 4'd0;
		item_ch.key_pressed = 1'b0;
		cfg_we = 1'b0;
		cfg_index = kda_pkg::CFG_REPEAT_PERIOD;
		cfg_data = 16'd0;
		q_phase = kda_pkg::PH_IDLE;
		q_owner = 4'd0;
		q_key_cnt = 16'd0;
		q_menu_cnt = 13'd0;
		q_menu_sel = 8'd0;
		q_backlight = 1'b0;
		q_period = 16'd0;
		q_delay = 16'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basics();
		test_release_paths();
		test_setting_extremes();
		test_default_settings();
		test_menu_wrap();
		test_random_sessions();

		settle();
		if (expected_beats.size() != 0) begin
			$error("%0d predicted beats never arrived", expected_beats.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
design/kda_pkg.sv
design/kda_if.sv
design/kda_step.sv
design/key_debounce_autorepeat.sv
design/kda_checker.sv
verif/key_debounce_autorepeat_test.sv
